/* rtl/wpc_pkg.sv */
package wpc_pkg;

  localparam int DEF_FRAC_BITS    = 16;
  localparam int DEF_CORDIC_STEPS = 16;

  // angle format of the CORDIC core
  localparam int    ANG_BITS  = 30;
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint NORM_LIM   = 64'sd1 << 40;

  // CORDIC datapath and angle accumulator widths
  localparam int CW = 46;
  localparam int ZW = 36;

  localparam int QDEPTH = 2;

  localparam logic [1:0] CMD_POSE = 2'd0;
  localparam logic [1:0] CMD_GOAL = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] REG_GAIN_FWD  = 3'd0;
  localparam logic [2:0] REG_GAIN_VERT = 3'd1;
  localparam logic [2:0] REG_GAIN_TURN = 3'd2;
  localparam logic [2:0] REG_LIM_FWD   = 3'd3;
  localparam logic [2:0] REG_LIM_VERT  = 3'd4;
  localparam logic [2:0] REG_LIM_TURN  = 3'd5;
  localparam logic [2:0] REG_ARRIVE    = 3'd6;
  localparam logic [2:0] REG_ALIGN     = 3'd7;

  typedef struct packed {
    logic [20:0] gain_forward;
    logic [20:0] gain_vertical;
    logic [20:0] gain_turn;
    logic [22:0] limit_forward;
    logic [22:0] limit_vertical;
    logic [22:0] limit_turn;
    logic [26:0] arrive_radius;
    logic [17:0] align_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_forward:   21'd39322,
    gain_vertical:  21'd65536,
    gain_turn:      21'd78643,
    limit_forward:  23'd393216,
    limit_vertical: 23'd98304,
    limit_turn:     23'd98304,
    arrive_radius:  27'd131072,
    align_limit:    18'd34315
  };

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } item_t;

  typedef struct packed {
    logic signed [23:0] vel_forward;
    logic signed [23:0] vel_vertical;
    logic signed [23:0] vel_turn;
    logic               moving;
  } res_t;

  // atan(2^-i) in Q30 radians
  function automatic logic [29:0] atan_q30(logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/wpc_front.sv */
module wpc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w (lowest bits first)
  input  logic [159:0]    in_tdata,
  // cmd
  input  logic [1:0]      in_tuser,
  output logic            q_valid,
  output wpc_pkg::item_t  q_item,
  input  logic            q_pop
);
  import wpc_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  item_t          fifo_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           push, pop;
  item_t          item;

  // unused command code is taken and dropped here
  assign in_tready = (cnt_r != (QAW+1)'(QDEPTH));
  assign push      = in_tvalid && in_tready && (in_tuser inside {CMD_POSE, CMD_GOAL, CMD_TICK});
  assign pop       = q_pop && q_valid;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = fifo_r[rd_ptr_r];

  always_comb begin
    item.cmd = in_tuser;
    item.px  = in_tdata[31:0];
    item.py  = in_tdata[63:32];
    item.pz  = in_tdata[95:64];
    item.qx  = in_tdata[111:96];
    item.qy  = in_tdata[127:112];
    item.qz  = in_tdata[143:128];
    item.qw  = in_tdata[159:144];
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* rtl/wpc_cordic.sv */
module wpc_cordic #(
  parameter int STEPS = wpc_pkg::DEF_CORDIC_STEPS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [wpc_pkg::CW-1:0] y_in,
  input  logic signed [wpc_pkg::CW-1:0] x_in,
  output logic                         done,
  output logic signed [wpc_pkg::ZW-1:0] z_out
);
  import wpc_pkg::*;

  localparam int IW = $clog2(STEPS);
  localparam logic signed [CW-1:0] LIM  = CW'(NORM_LIM);
  localparam logic signed [ZW-1:0] PI_Z = ZW'(PI_Q30);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_NORM = 4'b0010,
    C_ROT  = 4'b0100,
    C_DONE = 4'b1000
  } cstate_t;

  cstate_t              state_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r, da;
  logic [IW-1:0]        i_r;
  logic                 below_lim;

  assign below_lim = (x_r < LIM) && (x_r > -LIM) && (y_r < LIM) && (y_r > -LIM);
  assign da        = ZW'(atan_q30(5'(i_r)));
  assign done      = (state_r == C_DONE);
  assign z_out     = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (start) begin
            x_r <= x_in;
            y_r <= y_in;
            z_r <= '0;
            state_r <= (x_in == '0 && y_in == '0) ? C_DONE : C_NORM;
          end
        end
        C_NORM: begin
          // scale up one bit a cycle until either component reaches 2^40
          if (below_lim) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            if (x_r < 0) begin
              z_r <= (y_r >= 0) ? PI_Z : -PI_Z;
              x_r <= -x_r;
              y_r <= -y_r;
            end
            i_r     <= '0;
            state_r <= C_ROT;
          end
        end
        C_ROT: begin
          if (y_r > 0) begin
            x_r <= x_r + (y_r >>> i_r);
            y_r <= y_r - (x_r >>> i_r);
            z_r <= z_r + da;
          end else begin
            x_r <= x_r - (y_r >>> i_r);
            y_r <= y_r + (x_r >>> i_r);
            z_r <= z_r - da;
          end
          i_r <= i_r + 1'b1;
          if (i_r == IW'(STEPS-1)) state_r <= C_DONE;
        end
        C_DONE:  state_r <= C_IDLE;
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

/* rtl/wpc_isqrt.sv */
module wpc_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);
  import wpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } sstate_t;

  sstate_t     state_r;
  logic [63:0] v_r, r_r, bit_r, trial;

  assign trial = r_r + bit_r;
  assign done  = (state_r == S_DONE);
  assign root  = r_r[31:0];

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            v_r     <= val;
            r_r     <= '0;
            bit_r   <= 64'd1 << 62;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (v_r >= trial) begin
            v_r <= v_r - trial;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) state_r <= S_DONE;
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/wpc_back.sv */
module wpc_back #(
  parameter int FRAC_BITS    = wpc_pkg::DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = wpc_pkg::DEF_CORDIC_STEPS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  wpc_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  wpc_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output wpc_pkg::res_t   res
);
  import wpc_pkg::*;

  localparam logic signed [ZW-1:0] PI_Z     = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0] TWO_PI_Z = ZW'(TWO_PI_Q30);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_DIST   = 16'h0002,
    ST_QUAT   = 16'h0004,
    ST_YAWN   = 16'h0008,
    ST_YAWN_W = 16'h0010,
    ST_YAWG   = 16'h0020,
    ST_YAWG_W = 16'h0040,
    ST_TURN_M = 16'h0080,
    ST_TURN   = 16'h0100,
    ST_HD     = 16'h0200,
    ST_SQ_W   = 16'h0400,
    ST_FWD_M  = 16'h0800,
    ST_FWD    = 16'h1000,
    ST_VERT_M = 16'h2000,
    ST_VERT   = 16'h4000,
    ST_EMIT   = 16'h8000
  } state_t;

  state_t state_r;
  logic [3:0] step_r;
  logic pose_seen_r, nav_r, out_valid_r;
  res_t res_r;

  logic signed [31:0] hx_r, hy_r, hz_r, gx_r, gy_r, gz_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [32:0] ex_r, ey_r, ez_r;
  logic [32:0] aex, aey, aez;
  logic near;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod_r;
  logic [67:0] prod_u, pshift, acc_r;

  logic signed [33:0] qd_r, yz_r, m_r, s_r;
  logic [33:0] am;
  logic lock;

  logic signed [ZW-1:0] yn_r, err_r, e0, e1, e2, err_nxt;
  logic [ZW-1:0] aerr;
  logic [31:0] ux_r, uy_r;
  logic sh_r, big;
  logic [32:0] hd_r;
  logic signed [23:0] vf_r, vv_r, vt_r;
  logic mv_r;

  logic c_start, c_done;
  logic signed [CW-1:0] c_y, c_x;
  logic signed [ZW-1:0] c_z;
  logic s_start, s_done;
  logic [63:0] s_val;
  logic [31:0] s_root;

  function automatic logic signed [23:0] clamp_cmd(logic [67:0] p, logic [22:0] lim,
                                                   logic neg);
    logic [23:0] m;
    m = (p > {45'b0, lim}) ? {1'b0, lim} : p[23:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  assign aex  = ex_r[32] ? 33'(-ex_r) : 33'(ex_r);
  assign aey  = ey_r[32] ? 33'(-ey_r) : 33'(ey_r);
  assign aez  = ez_r[32] ? 33'(-ez_r) : 33'(ez_r);
  assign near = (aex < 33'd134217728) && (aey < 33'd134217728) && (aez < 33'd134217728);
  assign big  = aex[32] | aex[31] | aey[32] | aey[31];

  assign prod_u = prod_r;
  assign pshift = prod_u >> FRAC_BITS;

  assign am   = m_r[33] ? 34'(-m_r) : 34'(m_r);
  // gimbal lock or a zero quaternion gives zero yaw
  assign lock = ({am, 1'b0} >= {1'b0, qd_r});

  assign aerr = err_r[ZW-1] ? ZW'(-err_r) : ZW'(err_r);

  // yaw error wrapped once into +-pi, then down to FRAC_BITS
  always_comb begin
    e0      = c_z - yn_r;
    e1      = (e0 > PI_Z) ? e0 - TWO_PI_Z : e0;
    e2      = (e1 < -PI_Z) ? e1 + TWO_PI_Z : e1;
    err_nxt = e2 >>> (ANG_BITS - FRAC_BITS);
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_DIST: begin
        case (step_r)
          4'd0: begin ma = $signed({1'b0, aex}); mb = $signed({1'b0, aex}); end
          4'd1: begin ma = $signed({1'b0, aey}); mb = $signed({1'b0, aey}); end
          4'd2: begin ma = $signed({1'b0, aez}); mb = $signed({1'b0, aez}); end
          4'd3: begin
            ma = $signed({7'b0, cfg.arrive_radius});
            mb = $signed({7'b0, cfg.arrive_radius});
          end
          default: ;
        endcase
      end
      ST_QUAT: begin
        case (step_r)
          4'd0: begin ma = 34'(qx_r); mb = 34'(qx_r); end
          4'd1: begin ma = 34'(qy_r); mb = 34'(qy_r); end
          4'd2: begin ma = 34'(qz_r); mb = 34'(qz_r); end
          4'd3: begin ma = 34'(qw_r); mb = 34'(qw_r); end
          4'd4: begin ma = 34'(qx_r); mb = 34'(qz_r); end
          4'd5: begin ma = 34'(qw_r); mb = 34'(qy_r); end
          4'd6: begin ma = 34'(qx_r); mb = 34'(qy_r); end
          4'd7: begin ma = 34'(qw_r); mb = 34'(qz_r); end
          default: ;
        endcase
      end
      ST_TURN_M: begin
        ma = $signed({13'b0, cfg.gain_turn});
        mb = $signed({1'b0, aerr[32:0]});
      end
      ST_HD: begin
        case (step_r)
          4'd0: begin ma = $signed({2'b0, ux_r}); mb = $signed({2'b0, ux_r}); end
          4'd1: begin ma = $signed({2'b0, uy_r}); mb = $signed({2'b0, uy_r}); end
          default: ;
        endcase
      end
      ST_FWD_M: begin
        ma = $signed({13'b0, cfg.gain_forward});
        mb = $signed({1'b0, hd_r});
      end
      ST_VERT_M: begin
        ma = $signed({13'b0, cfg.gain_vertical});
        mb = $signed({1'b0, aez});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  assign c_start = ((state_r == ST_YAWN) && !lock) || (state_r == ST_YAWG);
  assign c_y     = (state_r == ST_YAWN) ? (CW'(s_r) <<< 1) : CW'(ey_r);
  assign c_x     = (state_r == ST_YAWN) ? (CW'(qd_r) - (CW'(yz_r) <<< 1)) : CW'(ex_r);

  assign s_start = (state_r == ST_HD) && (step_r == 4'd2);
  assign s_val   = acc_r[63:0] + prod_u[63:0];

  wpc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_start),
    .y_in  (c_y),
    .x_in  (c_x),
    .done  (c_done),
    .z_out (c_z)
  );

  wpc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (s_start),
    .val   (s_val),
    .done  (s_done),
    .root  (s_root)
  );

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pose_seen_r <= 1'b0;
      nav_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.cmd)
              CMD_POSE: begin
                hx_r <= q_item.px;
                hy_r <= q_item.py;
                hz_r <= q_item.pz;
                qx_r <= q_item.qx;
                qy_r <= q_item.qy;
                qz_r <= q_item.qz;
                qw_r <= q_item.qw;
                pose_seen_r <= 1'b1;
              end
              CMD_GOAL: begin
                gx_r  <= q_item.px;
                gy_r  <= q_item.py;
                gz_r  <= q_item.pz;
                nav_r <= 1'b1;
              end
              CMD_TICK: begin
                if (pose_seen_r) begin
                  if (!nav_r) begin
                    vf_r    <= '0;
                    vv_r    <= '0;
                    vt_r    <= '0;
                    mv_r    <= 1'b0;
                    state_r <= ST_EMIT;
                  end else begin
                    ex_r    <= 33'(gx_r) - 33'(hx_r);
                    ey_r    <= 33'(gy_r) - 33'(hy_r);
                    ez_r    <= 33'(gz_r) - 33'(hz_r);
                    step_r  <= '0;
                    state_r <= ST_DIST;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIST: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd1:       acc_r <= prod_u;
            4'd2, 4'd3: acc_r <= acc_r + prod_u;
            4'd4: begin
              step_r <= '0;
              // squared distance against squared radius
              if (near && (acc_r < prod_u)) begin
                nav_r   <= 1'b0;
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_QUAT;
              end
            end
            default: ;
          endcase
        end
        ST_QUAT: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd1: qd_r <= prod_r[33:0];
            4'd2: begin qd_r <= qd_r + prod_r[33:0]; yz_r <= prod_r[33:0]; end
            4'd3: begin qd_r <= qd_r + prod_r[33:0]; yz_r <= yz_r + prod_r[33:0]; end
            4'd4: qd_r <= qd_r + prod_r[33:0];
            4'd5: m_r  <= prod_r[33:0];
            4'd6: m_r  <= m_r - prod_r[33:0];
            4'd7: s_r  <= prod_r[33:0];
            4'd8: begin
              s_r     <= s_r + prod_r[33:0];
              step_r  <= '0;
              state_r <= ST_YAWN;
            end
            default: ;
          endcase
        end
        ST_YAWN: begin
          if (lock) begin
            yn_r    <= '0;
            state_r <= ST_YAWG;
          end else begin
            state_r <= ST_YAWN_W;
          end
        end
        ST_YAWN_W: begin
          if (c_done) begin
            yn_r    <= c_z;
            state_r <= ST_YAWG;
          end
        end
        ST_YAWG: state_r <= ST_YAWG_W;
        ST_YAWG_W: begin
          if (c_done) begin
            err_r   <= err_nxt;
            state_r <= ST_TURN_M;
          end
        end
        ST_TURN_M: state_r <= ST_TURN;
        ST_TURN: begin
          vt_r <= clamp_cmd(pshift, cfg.limit_turn, err_r[ZW-1]);
          if (aerr < {{(ZW-18){1'b0}}, cfg.align_limit}) begin
            ux_r    <= big ? aex[32:1] : aex[31:0];
            uy_r    <= big ? aey[32:1] : aey[31:0];
            sh_r    <= big;
            step_r  <= '0;
            state_r <= ST_HD;
          end else begin
            vf_r    <= '0;
            state_r <= ST_VERT_M;
          end
        end
        ST_HD: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd1: acc_r <= prod_u;
            4'd2: begin
              step_r  <= '0;
              state_r <= ST_SQ_W;
            end
            default: ;
          endcase
        end
        ST_SQ_W: begin
          if (s_done) begin
            hd_r    <= sh_r ? {s_root, 1'b0} : {1'b0, s_root};
            state_r <= ST_FWD_M;
          end
        end
        ST_FWD_M: state_r <= ST_FWD;
        ST_FWD: begin
          vf_r    <= clamp_cmd(pshift, cfg.limit_forward, 1'b0);
          state_r <= ST_VERT_M;
        end
        ST_VERT_M: state_r <= ST_VERT;
        ST_VERT: begin
          vv_r    <= clamp_cmd(pshift, cfg.limit_vertical, ez_r[32]);
          mv_r    <= 1'b1;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            res_r.vel_forward  <= vf_r;
            res_r.vel_vertical <= vv_r;
            res_r.vel_turn     <= vt_r;
            res_r.moving       <= mv_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/waypoint_p_controller_core.sv */
// Proportional waypoint controller. Input transfers carry a pose update, a goal
// update or a control tick (cmd in in_tuser); a two-entry queue sits between the
// input and the sequencer, so the input keeps taking transfers while a tick is
// being worked and the queue has room. Pose and goal items retire in the
// sequencer's idle state. A tick that navigates runs on one shared multiplier
// and, unless it arrives, one or two CORDIC runs (the first skipped on gimbal
// lock; each a normalizing loop, then CORDIC_STEPS rotations) and a square root
// that only runs when the heading is aligned; its time varies with the CORDIC
// normalizing loop and with whether the square root runs. An idle tick gives a
// zero result; a tick before any pose, or one that arrives at the goal, gives no
// result. Results sit in an output register until taken. Configuration writes
// are taken in any cycle and are meant for when the block is idle.
module waypoint_p_controller_core #(
  parameter int FRAC_BITS    = wpc_pkg::DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = wpc_pkg::DEF_CORDIC_STEPS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w (lowest bits first)
  input  logic [159:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vel_forward, vel_vertical, vel_turn (lowest bits first)
  output logic [71:0]  out_tdata,
  // moving
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [26:0]  cfg_data
);
  import wpc_pkg::*;

  cfg_t  cfg_r;
  logic  q_valid, q_pop;
  item_t q_item;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_GAIN_FWD:  cfg_r.gain_forward   <= cfg_data[20:0];
        REG_GAIN_VERT: cfg_r.gain_vertical  <= cfg_data[20:0];
        REG_GAIN_TURN: cfg_r.gain_turn      <= cfg_data[20:0];
        REG_LIM_FWD:   cfg_r.limit_forward  <= cfg_data[22:0];
        REG_LIM_VERT:  cfg_r.limit_vertical <= cfg_data[22:0];
        REG_LIM_TURN:  cfg_r.limit_turn     <= cfg_data[22:0];
        REG_ARRIVE:    cfg_r.arrive_radius  <= cfg_data;
        REG_ALIGN:     cfg_r.align_limit    <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  wpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  wpc_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.vel_turn, res.vel_vertical, res.vel_forward};
  assign out_tuser = res.moving;

endmodule
